FILE: hw/rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the ppm pulse train decoder
// Timing windows, scaling constants and the word passed between the decode
// stage and the scale stage.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // default number of channels per frame
  localparam int CHANNELS_DEF = 8;

  // field widths
  localparam int EDGE_W  = 16;
  localparam int WIDTH_W = 15;
  localparam int GAIN_W  = 6;
  localparam int INDEX_W = 3;
  localparam int VALUE_W = 14;
  localparam int PROD_W  = 16;
  localparam int QUOT_W  = 13;

  // pulse width windows in microseconds, all bounds exclusive
  localparam logic [WIDTH_W-1:0] SYNC_MIN_US  = 15'd4000;
  localparam logic [WIDTH_W-1:0] SYNC_MAX_US  = 15'd19000;
  localparam logic [WIDTH_W-1:0] PULSE_MIN_US = 15'd800;
  localparam logic [WIDTH_W-1:0] PULSE_MAX_US = 15'd2200;
  localparam logic [WIDTH_W-1:0] CENTER_US    = 15'd1500;

  // gain scale is (gain_step + GAIN_BASE) / GAIN_BASE
  localparam logic [6:0] GAIN_BASE = 7'd10;

  // divide by ten as multiply by reciprocal, exact for 16-bit operands
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // decoded word between decode and scale stages
  typedef struct packed {
    logic               channel_valid;
    logic [INDEX_W-1:0] channel_index;
    logic               negative;
    logic [PROD_W-1:0]  product;
    logic               sync_seen;
    logic               frame_lost;
  } ppd_mid_t;

endpackage

FILE: hw/rtl/ppm_pulse_train_decoder.sv
// ----------------------------------------------------------------------------
// ppm_pulse_train_decoder: radio-control ppm pulse train decoder
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------------
//   in_      | input     | in_valid/in_stall | in_edge_time
//   out_     | output    | out_valid/out_stall | channel valid/index/value, sync, lost
//   cfg_     | input     | cfg_we            | cfg_wdata (gain_step)
//
// One word per cycle sustained while out_stall is low; an accepted word passes the
// input register, decode/multiply register and scale/result register in turn.
// Synchronous active-low reset clears stage valids, frame state and gain_step.
// out_stall holds the result register; the pipeline keeps filling and
// in_stall rises only once all three stages hold words.
// ----------------------------------------------------------------------------
module ppm_pulse_train_decoder #(
  parameter int CHANNELS = ppd_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppd_pkg::EDGE_W-1:0]         in_edge_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_channel_valid,
  output logic [ppd_pkg::INDEX_W-1:0]        out_channel_index,
  output logic signed [ppd_pkg::VALUE_W-1:0] out_channel_value,
  output logic                               out_sync_seen,
  output logic                               out_frame_lost,
  input  logic                               cfg_we,
  input  logic [ppd_pkg::GAIN_W-1:0]         cfg_wdata
);

  logic                       in_valid_r;
  logic [ppd_pkg::EDGE_W-1:0] edge_time_r;
  logic [ppd_pkg::GAIN_W-1:0] gain_step_r;
  logic                       mid_valid_r;
  ppd_pkg::ppd_mid_t          mid_r;
  logic                       out_load;
  logic                       mid_load;
  logic                       in_load;

  // stage load enables, back from the output
  assign out_load = !out_valid || !out_stall;
  assign mid_load = !mid_valid_r || out_load;
  assign in_load  = !in_valid_r || mid_load;
  assign in_stall = !in_load;

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_step_r <= '0;
    end else if (cfg_we) begin
      gain_step_r <= cfg_wdata;
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      edge_time_r <= in_edge_time;
    end
  end

  // width classification and gain product
  ppd_decode #(
    .CHANNELS (CHANNELS)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (mid_load),
    .in_valid    (in_valid_r),
    .edge_time   (edge_time_r),
    .gain_step   (gain_step_r),
    .mid_valid_r (mid_valid_r),
    .mid_r       (mid_r)
  );

  // scaling and result register
  ppd_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (out_load),
    .mid_valid       (mid_valid_r),
    .mid             (mid_r),
    .out_valid_r     (out_valid),
    .channel_valid_r (out_channel_valid),
    .channel_index_r (out_channel_index),
    .channel_value_r (out_channel_value),
    .sync_seen_r     (out_sync_seen),
    .frame_lost_r    (out_frame_lost)
  );

endmodule

FILE: hw/rtl/ppd_decode.sv
// ----------------------------------------------------------------------------
// ppd_decode: pulse width measurement and frame tracking
// Measures the edge-to-edge width, classifies it as sync, channel pulse or
// fault, tracks the expected channel and forms the unscaled gain product.
// ----------------------------------------------------------------------------
module ppd_decode #(
  parameter int CHANNELS = ppd_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         in_valid,
  input  logic [ppd_pkg::EDGE_W-1:0]   edge_time,
  input  logic [ppd_pkg::GAIN_W-1:0]   gain_step,
  output logic                         mid_valid_r,
  output ppd_pkg::ppd_mid_t            mid_r
);

  localparam int NCW = $clog2(CHANNELS + 2);

  logic [ppd_pkg::EDGE_W-1:0]  prev_edge_r;
  logic [NCW-1:0]              next_chan_r;
  logic [NCW-1:0]              next_chan_nxt;
  logic [ppd_pkg::EDGE_W-1:0]  diff;
  logic [ppd_pkg::WIDTH_W-1:0] width_us;
  logic                        is_sync;
  logic                        is_pulse;
  logic                        armed;
  logic [NCW-1:0]              idx_full;
  logic [9:0]                  dev_mag;
  logic [6:0]                  scale_fac;
  logic [16:0]                 prod_full;
  logic                        advance;
  ppd_pkg::ppd_mid_t           mid_nxt;

  assign advance = load && in_valid;

  // width in microseconds, modulo timer wrap
  always_comb begin
    diff     = edge_time - prev_edge_r;
    width_us = diff[ppd_pkg::EDGE_W-1:1];
    is_sync  = (width_us > ppd_pkg::SYNC_MIN_US) && (width_us < ppd_pkg::SYNC_MAX_US);
    is_pulse = (width_us > ppd_pkg::PULSE_MIN_US) && (width_us < ppd_pkg::PULSE_MAX_US);
    armed    = (next_chan_r != '0) && (next_chan_r <= NCW'(CHANNELS));
    idx_full = next_chan_r - NCW'(1);
  end

  // deviation magnitude and gain product
  always_comb begin
    if (width_us >= ppd_pkg::CENTER_US) begin
      dev_mag = 10'(width_us - ppd_pkg::CENTER_US);
    end else begin
      dev_mag = 10'(ppd_pkg::CENTER_US - width_us);
    end
    scale_fac = 7'(gain_step) + ppd_pkg::GAIN_BASE;
    prod_full = 17'(dev_mag) * 17'(scale_fac);
  end

  // classification and next channel
  always_comb begin
    mid_nxt       = '0;
    next_chan_nxt = next_chan_r;
    if (is_sync) begin
      next_chan_nxt     = NCW'(1);
      mid_nxt.sync_seen = 1'b1;
    end else if (armed) begin
      if (is_pulse) begin
        next_chan_nxt         = next_chan_r + NCW'(1);
        mid_nxt.channel_valid = 1'b1;
        mid_nxt.channel_index = ppd_pkg::INDEX_W'(idx_full);
        mid_nxt.negative      = (width_us < ppd_pkg::CENTER_US);
        mid_nxt.product       = prod_full[ppd_pkg::PROD_W-1:0];
      end else begin
        next_chan_nxt      = '0;
        mid_nxt.frame_lost = 1'b1;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r <= '0;
      next_chan_r <= '0;
    end else if (advance) begin
      prev_edge_r <= edge_time;
      next_chan_r <= next_chan_nxt;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (load) begin
      mid_valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      mid_r <= mid_nxt;
    end
  end

  // checks
  a_sync_not_chan: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid_r |-> !(mid_r.sync_seen && mid_r.channel_valid))
    else $error("sync and channel word in one result");

  a_lost_not_chan: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid_r |-> !(mid_r.frame_lost && mid_r.channel_valid))
    else $error("frame lost and channel word in one result");

  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_chan_r <= NCW'(CHANNELS + 1))
    else $error("expected channel past end of frame");

  a_sync_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_sync) |=> (next_chan_r == NCW'(1)))
    else $error("sync did not arm first channel");

endmodule

FILE: hw/rtl/ppd_scale.sv
// ----------------------------------------------------------------------------
// ppd_scale: divide by ten and sign restore
// Turns the gain product into the signed channel value, truncating toward
// zero, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module ppd_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          mid_valid,
  input  ppd_pkg::ppd_mid_t             mid,
  output logic                          out_valid_r,
  output logic                          channel_valid_r,
  output logic [ppd_pkg::INDEX_W-1:0]   channel_index_r,
  output logic signed [ppd_pkg::VALUE_W-1:0] channel_value_r,
  output logic                          sync_seen_r,
  output logic                          frame_lost_r
);

  logic [31:0]                  recip_prod;
  logic [ppd_pkg::QUOT_W-1:0]   quot;
  logic [ppd_pkg::VALUE_W-1:0]  quot_ext;
  logic [ppd_pkg::VALUE_W-1:0]  value_nxt;

  // magnitude / 10 by reciprocal, then apply sign
  always_comb begin
    recip_prod = 32'(mid.product) * 32'(ppd_pkg::RECIP_10);
    quot       = recip_prod[ppd_pkg::RECIP_SHIFT +: ppd_pkg::QUOT_W];
    quot_ext   = ppd_pkg::VALUE_W'(quot);
    value_nxt  = mid.negative ? (ppd_pkg::VALUE_W'(0) - quot_ext) : quot_ext;
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= mid_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && mid_valid) begin
      channel_valid_r <= mid.channel_valid;
      channel_index_r <= mid.channel_index;
      channel_value_r <= value_nxt;
      sync_seen_r     <= mid.sync_seen;
      frame_lost_r    <= mid.frame_lost;
    end
  end

endmodule
